// ===== hdl/stni_pkg.sv =====
// shared types and constants for the sorted table nearest index block
package stni_pkg;

  // input word modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // command queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // field widths
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 10;
  localparam int POS_W   = 11;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] closest_index;
    logic [POS_W-1:0]   insert_position;
  } out_word_t;

  // classified operation carried from front to back
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
  } queue_status_t;

  // queue read side seen by the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// ===== hdl/stni_front.sv =====
// front end: accepts input words and classifies them into queue commands
module stni_front (
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  stni_pkg::in_word_t     in_word,
  input  stni_pkg::queue_status_t q_status,
  output logic                   push_valid,
  output stni_pkg::cmd_t         push_cmd
);
  import stni_pkg::*;

  logic known_mode;
  op_t  op;

  // stall while the queue has no room
  assign in_stall = q_status.full;

  // decode the mode; the unused code is taken and dropped
  always_comb begin
    known_mode = 1'b1;
    op         = OP_CLEAR;
    unique case (in_word.mode)
      MODE_CLEAR: begin
        op = OP_CLEAR;
      end
      MODE_APPEND: begin
        op = OP_APPEND;
      end
      MODE_QUERY: begin
        op = OP_QUERY;
      end
      default: begin
        known_mode = 1'b0;
      end
    endcase
  end

  assign push_valid     = in_valid && !in_stall && known_mode && rst_n;
  assign push_cmd.op    = op;
  assign push_cmd.value = in_word.value;

endmodule

// ===== hdl/stni_queue.sv =====
// small command queue between the front and the search engine
module stni_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  input  stni_pkg::cmd_t          push_cmd,
  output stni_pkg::queue_status_t status,
  output stni_pkg::queue_head_t   head,
  input  logic                    pop
);
  import stni_pkg::*;

  cmd_t                  slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]     fill_r, fill_nxt;
  logic                  do_push, do_pop;

  assign status.full = (fill_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head.valid  = (fill_r != '0);
  assign head.cmd    = slot_r[rd_ptr_r];

  assign do_push = push_valid && !status.full;
  assign do_pop  = pop && head.valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/stni_engine.sv =====
// back end: table memory, entry count, bisection search and result register
module stni_engine #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stni_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output stni_pkg::out_word_t   out_word
);
  import stni_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SEARCH   = 5'b00010,
    ST_NB_RIGHT = 5'b00100,
    ST_NB_LEFT  = 5'b01000,
    ST_DONE     = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             lo_r, lo_nxt;
  logic [CW-1:0]             hi_r, hi_nxt;
  logic [CW-1:0]             mid_r, mid_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic signed [VALUE_W-1:0] q_r, q_nxt;
  logic signed [VALUE_W-1:0] right_r, right_nxt;
  logic signed [VALUE_W-1:0] mem_r [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;
  logic                      out_valid_r;
  out_word_t                 out_word_r;
  logic                      out_free, out_load;

  // search step signals
  logic                      less;
  logic [CW-1:0]             lo_n, hi_n, mid_n, idx_c, idx_m1;
  logic signed [VALUE_W:0]   dist_left, dist_right;
  logic [CW+POS_W-1:0]       idx_wide, pos_wide;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign idx_m1    = idx_r - 1'b1;

  // one bisection step on the word just read
  always_comb begin
    less  = ($signed(rd_data_r) < $signed(q_r));
    lo_n  = less ? mid_r + 1'b1 : lo_r;
    hi_n  = less ? hi_r : mid_r;
    mid_n = lo_n + ((hi_n - lo_n) >> 1);
    if (lo_n == '0) begin
      idx_c = CW'(1);
    end else if (lo_n == count_r) begin
      idx_c = count_r - 1'b1;
    end else begin
      idx_c = lo_n;
    end
  end

  // neighbor distances at one extra bit so they cannot wrap
  assign dist_left  = {q_r[VALUE_W-1], q_r} - {rd_data_r[VALUE_W-1], rd_data_r};
  assign dist_right = {right_r[VALUE_W-1], right_r} - {q_r[VALUE_W-1], q_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    q_nxt     = q_r;
    right_nxt = right_r;
    rd_addr   = '0;
    wr_en     = 1'b0;
    pop       = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          unique case (head.cmd.op)
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_APPEND: begin
              if (count_r < CW'(TABLE_DEPTH)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              q_nxt  = head.cmd.value;
              lo_nxt = '0;
              hi_nxt = count_r;
              if (count_r == '0) begin
                pos_nxt   = '0;
                idx_nxt   = '0;
                state_nxt = ST_DONE;
              end else begin
                mid_nxt   = count_r >> 1;
                rd_addr   = mid_nxt[AW-1:0];
                state_nxt = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (lo_n < hi_n) begin
          lo_nxt  = lo_n;
          hi_nxt  = hi_n;
          mid_nxt = mid_n;
          rd_addr = mid_n[AW-1:0];
        end else begin
          pos_nxt = lo_n;
          if (count_r >= CW'(2)) begin
            idx_nxt   = idx_c;
            rd_addr   = idx_c[AW-1:0];
            state_nxt = ST_NB_RIGHT;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_NB_RIGHT: begin
        right_nxt = rd_data_r;
        rd_addr   = idx_m1[AW-1:0];
        state_nxt = ST_NB_LEFT;
      end
      ST_NB_LEFT: begin
        // step left only when the left entry is strictly closer
        if (dist_left < dist_right) begin
          idx_nxt = idx_m1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    pos_r   <= pos_nxt;
    idx_r   <= idx_nxt;
    q_r     <= q_nxt;
    right_r <= right_nxt;
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[count_r[AW-1:0]] <= head.cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  // result register, masked to the field widths
  assign idx_wide = {{POS_W{1'b0}}, idx_r};
  assign pos_wide = {{POS_W{1'b0}}, pos_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r.closest_index   <= idx_wide[INDEX_W-1:0];
      out_word_r.insert_position <= pos_wide[POS_W-1:0];
    end
  end

endmodule

// ===== hdl/sorted_table_nearest_index.sv =====
// Sorted table nearest index. Holds an ascending table of signed Q16.16 words
// (up to TABLE_DEPTH entries) and takes one word per handshake: clear, append,
// or query; mode 3 is taken and ignored. Appends to a full table are dropped.
// A query gives one result word: the lower-bound position (first entry not
// less than the query) and the index of the nearest entry, ties to the higher
// index; a table of zero or one entries gives index 0. Input words go into a
// four-deep command queue, so the input keeps flowing while a search runs
// until the queue fills. Clear and append are handled in the engine's idle
// state. A query is popped in the idle state, then takes one bisection step
// per cycle against the table memory, whose registered read sets that pace,
// then two reads for the neighbor pair (tables of two or more entries) and a
// load of the result register, which waits while the output is stalled. No
// clearing pass after reset.
module sorted_table_nearest_index #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stni_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output stni_pkg::out_word_t out_word
);
  import stni_pkg::*;

  queue_status_t q_status;
  queue_head_t   q_head;
  logic          push_valid;
  cmd_t          push_cmd;
  logic          pop;

  // classify incoming words
  stni_front u_front (
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  // decoupling queue
  stni_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .status     (q_status),
    .head       (q_head),
    .pop        (pop)
  );

  // table and search engine
  stni_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // queue never takes a command when full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !push_valid)
    else $error("command pushed into a full queue");

  // engine pops only a present command
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_head.valid)
    else $error("engine popped an empty queue");

  // a known-mode word taken at the input lands in the queue
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_word.mode != MODE_UNUSED) |-> push_valid)
    else $error("accepted word not queued");

endmodule

// ===== dv/tb.sv =====
// testbench for sorted_table_nearest_index: directed rows, table fill and random traffic
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stni_pkg::*;

  localparam int TABLE_DEPTH    = 1024;
  localparam int RANDOM_WORDS   = 450;
  localparam int HOLD_AFTER     = 1200;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  // one directed row: word to send and, where obvious, its result
  typedef struct packed {
    logic [1:0]                mode;
    logic signed [VALUE_W-1:0] value;
    bit                        typed;
    out_word_t                 result;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  // predictor state
  logic signed [VALUE_W-1:0] tbl_vals [TABLE_DEPTH];
  int unsigned               tbl_count;

  out_word_t pending_results [$];
  out_word_t oldest;
  stim_row_t directed_rows [$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  int        words_issued;
  int        burst_left;
  bit        hold_done = 1'b0;

  sorted_table_nearest_index #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // nearest entry and lower bound for a query against the current table
  function automatic out_word_t nearest_entry(input logic signed [VALUE_W-1:0] q);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned idx;
    longint      dist_left;
    longint      dist_right;
    out_word_t   r;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_vals[mid] < q) lo = mid + 1;
      else hi = mid;
    end
    idx = 0;
    if (tbl_count >= 2) begin
      idx = lo;
      if (idx < 1) idx = 1;
      if (idx > tbl_count - 1) idx = tbl_count - 1;
      dist_left  = longint'(q) - longint'(tbl_vals[idx - 1]);
      dist_right = longint'(tbl_vals[idx]) - longint'(q);
      // ties stay on the right
      if (dist_left < dist_right) idx = idx - 1;
    end
    r.closest_index   = idx[INDEX_W-1:0];
    r.insert_position = lo[POS_W-1:0];
    return r;
  endfunction

  // saturate a wide value into the q16.16 range
  function automatic logic signed [VALUE_W-1:0] to_q16(input longint v);
    if (v > longint'(VALUE_MAX)) return VALUE_MAX;
    if (v < longint'(VALUE_MIN)) return VALUE_MIN;
    return v[VALUE_W-1:0];
  endfunction

  task automatic add_row(input logic [1:0] mode, input logic signed [VALUE_W-1:0] value,
                         input bit typed, input int idx, input int pos);
    stim_row_t r;
    r.mode                   = mode;
    r.value                  = value;
    r.typed                  = typed;
    r.result.closest_index   = idx[INDEX_W-1:0];
    r.result.insert_position = pos[POS_W-1:0];
    directed_rows.push_back(r);
  endtask

  // update the predictor, then hand the word over and pace the bursts
  task automatic issue(input logic [1:0] mode, input logic signed [VALUE_W-1:0] value,
                       input bit typed, input out_word_t typed_result);
    in_word_t w;
    w.mode  = mode;
    w.value = value;
    case (mode)
      MODE_CLEAR: tbl_count = 0;
      MODE_APPEND: begin
        // a full table drops the append
        if (tbl_count < TABLE_DEPTH) begin
          tbl_vals[tbl_count] = value;
          tbl_count++;
        end
      end
      MODE_QUERY: pending_results.push_back(typed ? typed_result : nearest_entry(value));
      default: ;
    endcase
    if (mode != MODE_UNUSED) words_issued++;
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 10) $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word %h", out_word));
      end else begin
        oldest = pending_results.pop_front();
        if (out_word.closest_index !== oldest.closest_index)
          flag_mismatch($sformatf("closest_index expected %0d got %0d",
                                  oldest.closest_index, out_word.closest_index));
        if (out_word.insert_position !== oldest.insert_position)
          flag_mismatch($sformatf("insert_position expected %0d got %0d",
                                  oldest.insert_position, out_word.insert_position));
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off during random traffic
  initial begin
    int seg_len;
    int pct;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      seg_len = $urandom_range(10, 150);
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 25;
        2:       pct = 50;
        default: pct = 85;
      endcase
      repeat (seg_len) begin
        @(posedge clk);
        if (!hold_done && words_issued >= HOLD_AFTER) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // stimulus
  initial begin
    int                        i;
    int                        k;
    int                        n;
    int                        nq;
    int                        j;
    int                        pick;
    int                        off;
    int                        random_end;
    longint                    cur;
    longint                    step;
    logic signed [VALUE_W-1:0] rnd;
    logic signed [VALUE_W-1:0] qv;
    logic [1:0]                md;
    out_word_t                 typed_result;
    longint                    seq_vals [$];

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_word        = '0;
    tbl_count      = 0;
    words_issued   = 0;
    burst_left     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows: empty table, extremes, ties, unused mode, unsorted table
    add_row(MODE_QUERY,  32'sd0,       1'b1, 0, 0);
    add_row(MODE_APPEND, VALUE_MIN,    1'b0, 0, 0);
    add_row(MODE_QUERY,  32'sd0,       1'b1, 0, 1);
    add_row(MODE_QUERY,  VALUE_MIN,    1'b1, 0, 0);
    add_row(MODE_APPEND, -32'sd65536,  1'b0, 0, 0);
    add_row(MODE_APPEND, 32'sd0,       1'b0, 0, 0);
    add_row(MODE_APPEND, 32'sd65536,   1'b0, 0, 0);
    add_row(MODE_APPEND, VALUE_MAX,    1'b0, 0, 0);
    add_row(MODE_QUERY,  VALUE_MIN,    1'b1, 0, 0);
    add_row(MODE_QUERY,  VALUE_MAX,    1'b1, 4, 4);
    add_row(MODE_QUERY,  32'sd32768,   1'b1, 3, 3);
    add_row(MODE_QUERY,  32'sd32767,   1'b1, 2, 3);
    add_row(MODE_UNUSED, 32'sd32768,   1'b0, 0, 0);
    add_row(MODE_QUERY,  -32'sd65536,  1'b1, 1, 1);
    add_row(MODE_CLEAR,  32'sd0,       1'b0, 0, 0);
    add_row(MODE_QUERY,  32'sd12345,   1'b1, 0, 0);
    add_row(MODE_APPEND, VALUE_MAX,    1'b0, 0, 0);
    add_row(MODE_QUERY,  VALUE_MAX,    1'b1, 0, 0);
    add_row(MODE_APPEND, VALUE_MIN,    1'b0, 0, 0);
    add_row(MODE_QUERY,  32'sd0,       1'b0, 0, 0);
    add_row(MODE_CLEAR,  32'sd0,       1'b0, 0, 0);
    add_row(MODE_APPEND, VALUE_MIN,    1'b0, 0, 0);
    add_row(MODE_APPEND, VALUE_MAX,    1'b0, 0, 0);
    add_row(MODE_QUERY,  32'sd0,       1'b1, 1, 1);
    add_row(MODE_QUERY,  -32'sd1,      1'b1, 0, 1);
    foreach (directed_rows[i])
      issue(directed_rows[i].mode, directed_rows[i].value,
            directed_rows[i].typed, directed_rows[i].result);

    // fill the table to capacity, then push appends that must be dropped
    issue(MODE_CLEAR, 32'sd0, 1'b0, '0);
    seq_vals.delete();
    cur = -(longint'(1) << 30);
    for (i = 0; i < TABLE_DEPTH; i++) begin
      cur = cur + $urandom_range(0, 1 << 20);
      issue(MODE_APPEND, to_q16(cur), 1'b0, '0);
      seq_vals.push_back(cur);
    end
    for (i = 0; i < 6; i++) issue(MODE_APPEND, VALUE_MIN, 1'b0, '0);
    typed_result.closest_index   = INDEX_W'(TABLE_DEPTH - 1);
    typed_result.insert_position = POS_W'(TABLE_DEPTH);
    issue(MODE_QUERY, VALUE_MAX, 1'b1, typed_result);
    typed_result = '0;
    issue(MODE_QUERY, VALUE_MIN, 1'b1, typed_result);
    for (i = 0; i < 12; i++) begin
      j  = $urandom_range(0, TABLE_DEPTH - 2);
      qv = (i % 2 == 0) ? to_q16(seq_vals[j]) : to_q16((seq_vals[j] + seq_vals[j + 1]) >>> 1);
      issue(MODE_QUERY, qv, 1'b0, '0);
    end

    // random traffic: mostly clear, ascending fill and queries; some noise
    random_end = words_issued + RANDOM_WORDS;
    while (words_issued < random_end) begin
      if ($urandom_range(0, 99) < 80) begin
        issue(MODE_CLEAR, $urandom, 1'b0, '0);
        seq_vals.delete();
        n   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(13, 60);
        rnd = $urandom;
        cur = $urandom_range(0, 1) ? longint'(rnd)
                                   : longint'($urandom_range(0, 1 << 20)) - (1 << 19);
        for (i = 0; i < n; i++) begin
          issue(MODE_APPEND, to_q16(cur), 1'b0, '0);
          seq_vals.push_back(cur);
          case ($urandom_range(0, 2))
            0:       step = $urandom_range(0, 3);
            1:       step = $urandom_range(0, 65536);
            default: step = $urandom_range(0, 1 << 28);
          endcase
          cur = to_q16(cur + step);
        end
        nq = $urandom_range(1, 8);
        for (k = 0; k < nq; k++) begin
          pick = (seq_vals.size() == 0) ? 3 : $urandom_range(0, 5);
          j    = (seq_vals.size() == 0) ? 0 : $urandom_range(0, seq_vals.size() - 1);
          case (pick)
            0: qv = to_q16(seq_vals[j]);
            1: begin
              off = $urandom_range(0, 4);
              off = off - 2;
              qv  = to_q16(seq_vals[j] + off);
            end
            2: begin
              // midpoints make ties when the pair sum is even
              if (j + 1 < seq_vals.size()) qv = to_q16((seq_vals[j] + seq_vals[j + 1]) >>> 1);
              else qv = to_q16(seq_vals[j] + 1);
            end
            3: qv = $urandom;
            4: qv = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
            default: qv = to_q16(seq_vals[j] - 1);
          endcase
          issue(MODE_QUERY, qv, 1'b0, '0);
        end
      end else begin
        // noise: any mode, any value, unsorted appends on top of the table
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          md = 2'($urandom_range(0, 3));
          issue(md, $urandom, 1'b0, '0);
        end
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/stni_pkg.sv
hdl/stni_front.sv
hdl/stni_queue.sv
hdl/stni_engine.sv
hdl/sorted_table_nearest_index.sv
dv/tb.sv
